// ===== sv/rgb_vibrance_adjust_top_assert.svh =====
// Assertion macros for the vibrance adjust block checker.
`ifndef RGB_VIBRANCE_ADJUST_TOP_ASSERT_SVH
`define RGB_VIBRANCE_ADJUST_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle, reset masks the check.
`define RVA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rva: property violated");

// Antecedent implies consequent in the next cycle, reset masks the check.
`define RVA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rva: property violated");

// Checked while reset is asserted.
`define RVA_ASSERT_RST(label, cons) \
	label: assert property (@(posedge clk) !arst_n |-> (cons)) \
		else $error("rva: reset property violated");

`endif

// ===== sv/rva_pkg.sv =====
// Package with shared types, register indexes and luma coefficients.
`default_nettype none

package rva_pkg;

	typedef logic [1:0] luma_mode_t;
	typedef logic [1:0] chan_t;

	localparam int NUM_CH         = 3;
	localparam int LUMA_COEF_BITS = 16;
	localparam int APB_ADDR_BITS  = 3;
	localparam int APB_DATA_BITS  = 32;

	localparam chan_t CH_RED   = 2'd0;
	localparam chan_t CH_GREEN = 2'd1;
	localparam chan_t CH_BLUE  = 2'd2;

	localparam luma_mode_t LUMA_REC709  = 2'd0;
	localparam luma_mode_t LUMA_CCIR601 = 2'd1;
	localparam luma_mode_t LUMA_AVERAGE = 2'd2;
	localparam luma_mode_t LUMA_MAXIMUM = 2'd3;

	// register index, taken from paddr[2]
	localparam logic REG_GAIN = 1'b0;
	localparam logic REG_MODE = 1'b1;

	localparam logic [LUMA_COEF_BITS-1:0] K709_R = 16'd13933;
	localparam logic [LUMA_COEF_BITS-1:0] K709_G = 16'd46871;
	localparam logic [LUMA_COEF_BITS-1:0] K709_B = 16'd4732;
	localparam logic [LUMA_COEF_BITS-1:0] K601_R = 16'd19595;
	localparam logic [LUMA_COEF_BITS-1:0] K601_G = 16'd38470;
	localparam logic [LUMA_COEF_BITS-1:0] K601_B = 16'd7471;

	function automatic logic [LUMA_COEF_BITS-1:0] luma_coef(input luma_mode_t mode,
			input chan_t ch);
		logic [LUMA_COEF_BITS-1:0] k;
		k = '0;
		unique case (mode)
			LUMA_REC709: begin
				unique case (ch)
					CH_RED:   k = K709_R;
					CH_GREEN: k = K709_G;
					default:  k = K709_B;
				endcase
			end
			LUMA_CCIR601: begin
				unique case (ch)
					CH_RED:   k = K601_R;
					CH_GREEN: k = K601_G;
					default:  k = K601_B;
				endcase
			end
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== sv/rgb_vibrance_adjust_top.sv =====
// Vibrance adjust top level: the pixel stream and the register port.
//
// Pixels enter on the s_axis channel and leave on the m_axis channel, one
// result per accepted pixel, in order. A transfer happens when tvalid and
// tready are both high. tdata carries red, green and blue from bit 0 up,
// COMPONENT_BITS each, zero-padded to whole bytes.
// A new pixel can be taken every cycle while m_axis_tready is not holding the
// output. The seven stages of the datapath are the luma products, the luma
// sum with the average and the weight, the grey select, the gain product,
// the weight products split in two halves, the wide sum and the saturating
// output register.
// When the receiver holds m_axis_tready low the output holds, and bubbles in
// the pipeline still fill; s_axis_tready drops once every stage is full.
// Registers: vibrance_gain at 0x0 (Q3.GAIN_FRAC_BITS), luma_mode at 0x4.
// Write them only while no pixel is in flight. Reset empties the pipeline,
// sets the gain to 1.0 and selects Rec709 luma.
`default_nettype none

module rgb_vibrance_adjust_top #(
	parameter int COMPONENT_BITS = 16,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          s_axis_tvalid,
	output logic                                         s_axis_tready,
	// red_in, green_in, blue_in
	input  wire  [((3*COMPONENT_BITS+7)/8)*8-1:0]        s_axis_tdata,
	output logic                                         m_axis_tvalid,
	input  wire                                          m_axis_tready,
	// red_out, green_out, blue_out
	output logic [((3*COMPONENT_BITS+7)/8)*8-1:0]        m_axis_tdata,
	input  wire                                          psel,
	input  wire                                          penable,
	input  wire                                          pwrite,
	input  wire  [rva_pkg::APB_ADDR_BITS-1:0]            paddr,
	input  wire  [rva_pkg::APB_DATA_BITS-1:0]            pwdata,
	output logic [rva_pkg::APB_DATA_BITS-1:0]            prdata,
	output logic                                         pready
);
	import rva_pkg::*;

	localparam int N  = COMPONENT_BITS;
	localparam int GW = GAIN_FRAC_BITS + 3;

	localparam logic [GW-1:0] GAIN_UNITY = GW'(1) << GAIN_FRAC_BITS;

	logic [GW-1:0]             gain_q;
	luma_mode_t                mode_q;
	logic                      wr_en;
	logic [NUM_CH-1:0][N-1:0]  in_comp;
	logic [NUM_CH-1:0][N-1:0]  out_comp;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_UNITY;
			mode_q <= LUMA_REC709;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_GAIN: gain_q <= pwdata[GW-1:0];
				REG_MODE: mode_q <= luma_mode_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GAIN: prdata = APB_DATA_BITS'(gain_q);
			REG_MODE: prdata = APB_DATA_BITS'(mode_q);
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			in_comp[i]               = s_axis_tdata[i*N +: N];
			m_axis_tdata[i*N +: N]   = out_comp[i];
		end
	end

	rva_core #(
		.COMPONENT_BITS (COMPONENT_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (gain_q),
		.luma_mode (mode_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_comp   (in_comp),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_comp  (out_comp)
	);

endmodule

`default_nettype wire

// ===== sv/rva_core.sv =====
// Seven-stage vibrance datapath with per-stage valid and ready.
`default_nettype none

module rva_core #(
	parameter int COMPONENT_BITS = 16,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  wire                                              clk,
	input  wire                                              arst_n,
	input  wire  [GAIN_FRAC_BITS+2:0]                        gain,
	input  rva_pkg::luma_mode_t                              luma_mode,
	input  wire                                              in_valid,
	output logic                                             in_ready,
	input  wire  [rva_pkg::NUM_CH-1:0][COMPONENT_BITS-1:0]   in_comp,
	output logic                                             out_valid,
	input  wire                                              out_ready,
	output logic [rva_pkg::NUM_CH-1:0][COMPONENT_BITS-1:0]   out_comp
);
	import rva_pkg::*;

	localparam int N   = COMPONENT_BITS;
	localparam int F   = GAIN_FRAC_BITS;
	localparam int GW  = F + 3;
	localparam int KB  = LUMA_COEF_BITS;
	localparam int WL  = N / 2;
	localparam int WH  = N - WL;
	localparam int RK  = N + 3;
	localparam int DGW = N + GW + 2;
	localparam int TW  = 2 * N + F + 6;
	localparam int SH  = N + F;

	localparam logic [RK-1:0]        RECIP = RK'((64'd1 << RK) / 3 + 64'd1);
	localparam logic [N:0]           ONE   = (N+1)'(1) << N;
	localparam logic [N+KB+1:0]      LHALF = (N+KB+2)'(1) << (KB - 1);
	localparam logic signed [TW-1:0] ROUND = $signed(TW'(1) << (SH - 1));

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	logic [N-1:0]               comp_s1 [NUM_CH];
	logic [N+KB-1:0]            prod_s1 [NUM_CH];
	logic [N-1:0]               max_s1, min_s1;
	logic [N+1:0]               sum_s1;

	logic [N-1:0]               comp_s2 [NUM_CH];
	logic [N-1:0]               luma_s2, max_s2, w_s2;
	logic [N+RK+1:0]            avgp_s2;

	logic [N-1:0]               comp_s3 [NUM_CH];
	logic signed [N:0]          diff_s3 [NUM_CH];
	logic [N-1:0]               grey_s3, w_s3;

	logic signed [DGW-1:0]      dg_s4 [NUM_CH];
	logic [2*N:0]               cw_s4 [NUM_CH];
	logic [2*N-1:0]             gw_s4;
	logic [N-1:0]               w_s4;

	logic signed [DGW+WL:0]     bl_s5 [NUM_CH];
	logic signed [DGW+WH:0]     bh_s5 [NUM_CH];
	logic [2*N:0]               a_s5 [NUM_CH];

	logic signed [TW-1:0]       t_s6 [NUM_CH];

	logic [N-1:0]               res_s7 [NUM_CH];

	logic [N-1:0]               in_max, in_min;
	logic [N:0]                 wa, wb, wmin;
	logic [N+KB+1:0]            luma_sum;
	logic [N-1:0]               grey;
	logic [N:0]                 wcomp;
	logic signed [TW-1:0]       tsum [NUM_CH];
	logic [N-1:0]               sat [NUM_CH];

	assign rdy7     = !vld_s7 || out_ready;
	assign rdy6     = !vld_s6 || rdy7;
	assign rdy5     = !vld_s5 || rdy6;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		in_max = in_comp[0];
		in_min = in_comp[0];
		for (int i = 1; i < NUM_CH; i++) begin
			if (in_comp[i] > in_max) in_max = in_comp[i];
			if (in_comp[i] < in_min) in_min = in_comp[i];
		end
	end

	always_comb begin
		wa       = ONE - {1'b0, max_s1};
		wb       = {1'b0, max_s1 - min_s1};
		wmin     = (wa < wb) ? wa : wb;
		luma_sum = LHALF;
		for (int i = 0; i < NUM_CH; i++) begin
			luma_sum = luma_sum + (N+KB+2)'(prod_s1[i]);
		end
	end

	always_comb begin
		case (luma_mode) inside
			LUMA_REC709, LUMA_CCIR601: grey = luma_s2;
			LUMA_AVERAGE:              grey = avgp_s2[RK+N-1:RK];
			default:                   grey = max_s2;
		endcase
		wcomp = ONE - {1'b0, w_s3};
	end

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			tsum[i] = ($signed(TW'(a_s5[i])) <<< F) + (TW'(bh_s5[i]) <<< WL)
				+ TW'(bl_s5[i]) + ROUND;
			if (t_s6[i][TW-1]) begin
				sat[i] = '0;
			end else if (|t_s6[i][TW-2:2*N+F]) begin
				sat[i] = '1;
			end else begin
				sat[i] = t_s6[i][2*N+F-1:SH];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
			if (rdy7) vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int i = 0; i < NUM_CH; i++) begin
				comp_s1[i] <= in_comp[i];
				prod_s1[i] <= in_comp[i] * luma_coef(luma_mode, chan_t'(i));
			end
			max_s1 <= in_max;
			min_s1 <= in_min;
			sum_s1 <= (N+2)'(in_comp[0]) + (N+2)'(in_comp[1]) + (N+2)'(in_comp[2])
				+ (N+2)'(1);
		end
		if (rdy2 && vld_s1) begin
			comp_s2 <= comp_s1;
			luma_s2 <= luma_sum[N+KB-1:KB];
			avgp_s2 <= sum_s1 * RECIP;
			max_s2  <= max_s1;
			w_s2    <= wmin[N-1:0];
		end
		if (rdy3 && vld_s2) begin
			for (int i = 0; i < NUM_CH; i++) begin
				diff_s3[i] <= $signed({1'b0, comp_s2[i]}) - $signed({1'b0, grey});
			end
			comp_s3 <= comp_s2;
			grey_s3 <= grey;
			w_s3    <= w_s2;
		end
		if (rdy4 && vld_s3) begin
			for (int i = 0; i < NUM_CH; i++) begin
				dg_s4[i] <= diff_s3[i] * $signed({1'b0, gain});
				cw_s4[i] <= wcomp * comp_s3[i];
			end
			gw_s4 <= grey_s3 * w_s3;
			w_s4  <= w_s3;
		end
		if (rdy5 && vld_s4) begin
			for (int i = 0; i < NUM_CH; i++) begin
				bl_s5[i] <= dg_s4[i] * $signed({1'b0, w_s4[WL-1:0]});
				bh_s5[i] <= dg_s4[i] * $signed({1'b0, w_s4[N-1:WL]});
				a_s5[i]  <= (2*N+1)'(gw_s4) + cw_s4[i];
			end
		end
		if (rdy6 && vld_s5) begin
			t_s6 <= tsum;
		end
		if (rdy7 && vld_s6) begin
			res_s7 <= sat;
		end
	end

	assign out_valid = vld_s7;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			out_comp[i] = res_s7[i];
		end
	end

endmodule

`default_nettype wire

// ===== sv/rva_checker.sv =====
// Port-level checker for the vibrance adjust top level, with its bind.
`default_nettype none

`include "rgb_vibrance_adjust_top_assert.svh"

module rva_checker #(
	parameter int COMPONENT_BITS = 16,
	parameter int GAIN_FRAC_BITS = 12
) (
	input wire                                      clk,
	input wire                                      arst_n,
	input wire                                      m_axis_tvalid,
	input wire                                      m_axis_tready,
	input wire [((3*COMPONENT_BITS+7)/8)*8-1:0]     m_axis_tdata,
	input wire                                      psel,
	input wire                                      penable,
	input wire                                      pwrite,
	input wire [rva_pkg::APB_ADDR_BITS-1:0]         paddr,
	input wire [rva_pkg::APB_DATA_BITS-1:0]         pwdata,
	input wire [rva_pkg::APB_DATA_BITS-1:0]         prdata
);
	import rva_pkg::*;

	localparam int GW = GAIN_FRAC_BITS + 3;

	`RVA_ASSERT_RST(a_reset_empty, !m_axis_tvalid)

	`RVA_ASSERT_IMP(a_gain_readback, psel && penable && pwrite && (paddr[2] == REG_GAIN) ##1 psel && !pwrite && (paddr[2] == REG_GAIN), prdata[GW-1:0] == $past(pwdata[GW-1:0]))

	`RVA_ASSERT_IMP(a_mode_readback, psel && penable && pwrite && (paddr[2] == REG_MODE) ##1 psel && !pwrite && (paddr[2] == REG_MODE), prdata[1:0] == $past(pwdata[1:0]))

	`RVA_ASSERT_NXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	`RVA_ASSERT_NXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind rgb_vibrance_adjust_top rva_checker #(
	.COMPONENT_BITS (COMPONENT_BITS),
	.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
) u_rva_checker (.*);

`default_nettype wire
